>>> hdl/spisp_pkg.sv
// Shared types and constants for the SPI slave shift port.
package spisp_pkg;

   // Request command codes
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_PIN   = 2'd2;

   // Register selector codes
   localparam logic [1:0] SEL_CTRL = 2'd0;
   localparam logic [1:0] SEL_STAT = 2'd1;
   localparam logic [1:0] SEL_DATA = 2'd2;

   // Control register bit positions
   localparam int CTL_IRQ_EN_BIT = 7;
   localparam int CTL_ENABLE_BIT = 6;
   localparam int CTL_POL_BIT    = 3;
   localparam int CTL_PHASE_BIT  = 2;

   // Status register bit 7 is the done flag
   localparam int STAT_DONE_BIT = 7;

   localparam logic [3:0] BYTE_BITS = 4'd8;

   // One result of the core
   typedef struct packed {
      logic [7:0] read_byte;
      logic       miso_level;
      logic       irq_pulse;
      logic       done_flag;
   } rsp_type;

endpackage

>>> hdl/spi_slave_shift_port_core.sv
// Top level of the SPI slave shift port: request channel, core and result register.
// Latency: a result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the result slot is empty or its result is taken;
// the result register is the only stage, and it reloads in the same cycle that its held result is taken.
// Reset (synchronous, active high) clears all state registers but the result data to their idle values
// and empties the result register; no request is taken while reset is high.
module spi_slave_shift_port_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [1:0] req_reg_sel,
   input  logic [7:0] req_write_byte,
   input  logic       req_select_pin,
   input  logic       req_clock_pin,
   input  logic       req_mosi_pin,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_miso_level,
   output logic       rsp_irq_pulse,
   output logic       rsp_done_flag
);

   logic               accept;
   spisp_pkg::rsp_type core_rsp;
   spisp_pkg::rsp_type out_rsp;

   // Take a request whenever the result slot is free or being emptied
   assign req_ready = !reset && (!rsp_valid || rsp_ready);
   assign accept    = req_valid && req_ready;

   spisp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cmd        (req_cmd),
      .reg_sel    (req_reg_sel),
      .write_byte (req_write_byte),
      .select_pin (req_select_pin),
      .clock_pin  (req_clock_pin),
      .mosi_pin   (req_mosi_pin),
      .rsp        (core_rsp)
   );

   spisp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rsp_in    (core_rsp),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_out   (out_rsp)
   );

   assign rsp_read_byte  = out_rsp.read_byte;
   assign rsp_miso_level = out_rsp.miso_level;
   assign rsp_irq_pulse  = out_rsp.irq_pulse;
   assign rsp_done_flag  = out_rsp.done_flag;

endmodule

>>> hdl/spisp_core.sv
// Register file, pin-sample edge logic and per-request result for the SPI slave.
module spisp_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [1:0]         cmd,
   input  logic [1:0]         reg_sel,
   input  logic [7:0]         write_byte,
   input  logic               select_pin,
   input  logic               clock_pin,
   input  logic               mosi_pin,
   output spisp_pkg::rsp_type rsp
);

   logic [7:0] control_ff, control_in;
   logic [7:0] status_ff, status_in;
   logic [7:0] tx_ff, tx_in;
   logic [7:0] rx_ff, rx_in;
   logic [3:0] bits_ff, bits_in;
   logic       sck_ff, sck_in;
   logic       phase_ff, phase_in;
   logic       miso_ff, miso_in;

   logic       pha, pol, active;
   logic [7:0] read_byte;
   logic       irq;

   assign pha = control_ff[spisp_pkg::CTL_PHASE_BIT];
   assign pol = control_ff[spisp_pkg::CTL_POL_BIT];

   // Active edge: enabled pin sample, clock changed, select low, right phase, right clock level, armed.
   // The select level only matters in the request that samples it, so the pin is used.
   assign active = (cmd == spisp_pkg::CMD_PIN) && control_ff[spisp_pkg::CTL_ENABLE_BIT]
                   && (sck_ff != clock_pin) && !select_pin && (phase_ff == pha)
                   && (clock_pin == (pol ^ pha ^ 1'b1)) && (bits_ff != 4'd0);

   // Next state and result for the current request
   always_comb begin
      control_in = control_ff;
      status_in  = status_ff;
      tx_in      = tx_ff;
      rx_in      = rx_ff;
      bits_in    = bits_ff;
      sck_in     = sck_ff;
      phase_in   = phase_ff;
      miso_in    = miso_ff;
      read_byte  = 8'd0;
      irq        = 1'b0;
      case (cmd)
         spisp_pkg::CMD_READ: begin
            case (reg_sel)
               spisp_pkg::SEL_CTRL: read_byte = control_ff;
               spisp_pkg::SEL_STAT: read_byte = status_ff;
               spisp_pkg::SEL_DATA: begin
                  read_byte = rx_ff;
                  tx_in     = rx_ff;
               end
               default: read_byte = 8'd0;
            endcase
         end
         spisp_pkg::CMD_WRITE: begin
            case (reg_sel)
               spisp_pkg::SEL_CTRL: begin
                  control_in = write_byte;
                  bits_in    = spisp_pkg::BYTE_BITS;
                  status_in[spisp_pkg::STAT_DONE_BIT] = 1'b0;
               end
               spisp_pkg::SEL_STAT: status_in = {status_ff[7], write_byte[6:0]};
               spisp_pkg::SEL_DATA: begin
                  tx_in   = write_byte;
                  bits_in = spisp_pkg::BYTE_BITS;
                  status_in[spisp_pkg::STAT_DONE_BIT] = 1'b0;
               end
               default: ;
            endcase
         end
         spisp_pkg::CMD_PIN: begin
            if (control_ff[spisp_pkg::CTL_ENABLE_BIT]) begin
               sck_in    = clock_pin;
               if (sck_ff != clock_pin) begin
                  phase_in = ~phase_ff;
               end
               if (active) begin
                  miso_in = tx_ff[7];
                  bits_in = bits_ff - 4'd1;
                  if (bits_ff == 4'd1) begin
                     // last bit: keep bytes, flag completion
                     rx_in = {rx_ff[7:1], mosi_pin};
                     if (control_ff[spisp_pkg::CTL_IRQ_EN_BIT]) begin
                        irq = 1'b1;
                     end else begin
                        status_in[spisp_pkg::STAT_DONE_BIT] = 1'b1;
                     end
                  end else begin
                     tx_in = {tx_ff[6:0], 1'b0};
                     rx_in = {rx_ff[6:1], mosi_pin, 1'b0};
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // Result reflects state after this request
   always_comb begin
      rsp.read_byte  = read_byte;
      rsp.miso_level = miso_in;
      rsp.irq_pulse  = irq;
      rsp.done_flag  = status_in[spisp_pkg::STAT_DONE_BIT];
   end

   // State registers, updated once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= 8'd0;
         status_ff  <= 8'd0;
         tx_ff      <= 8'd0;
         rx_ff      <= 8'd0;
         bits_ff    <= 4'd0;
         sck_ff     <= 1'b0;
         phase_ff   <= 1'b0;
         miso_ff    <= 1'b0;
      end else if (accept) begin
         control_ff <= control_in;
         status_ff  <= status_in;
         tx_ff      <= tx_in;
         rx_ff      <= rx_in;
         bits_ff    <= bits_in;
         sck_ff     <= sck_in;
         phase_ff   <= phase_in;
         miso_ff    <= miso_in;
      end
   end

endmodule

>>> hdl/spisp_out.sv
// Result register with valid/ready handshake for the SPI slave.
module spisp_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  spisp_pkg::rsp_type rsp_in,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output spisp_pkg::rsp_type rsp_out
);

   logic               valid_ff, valid_in;
   spisp_pkg::rsp_type data_ff, data_in;

   // Load on accept, drop when taken
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = rsp_in;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_out   = data_ff;

endmodule

>>> hdl/spisp_checker.sv
// Port-level checks for the SPI slave shift port, bound to the top level.
module spisp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_cmd,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_byte,
   input logic       rsp_miso_level,
   input logic       rsp_irq_pulse,
   input logic       rsp_done_flag
);

   // An accepted request yields a result in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no result");

   // Only reads return data
   a_read_only_data: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd != spisp_pkg::CMD_READ) |=> rsp_read_byte == 8'd0)
      else $error("non-read request returned data");

   // Interrupt replaces the done flag on completion
   a_irq_no_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_irq_pulse |-> !rsp_done_flag)
      else $error("interrupt pulse with done flag set");

   // Stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_byte)
         && $stable(rsp_miso_level) && $stable(rsp_irq_pulse) && $stable(rsp_done_flag))
      else $error("stalled result changed");

endmodule

bind spi_slave_shift_port_core spisp_checker u_spisp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_cmd        (req_cmd),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_byte  (rsp_read_byte),
   .rsp_miso_level (rsp_miso_level),
   .rsp_irq_pulse  (rsp_irq_pulse),
   .rsp_done_flag  (rsp_done_flag)
);
